// ----- rtl/core/smt_pkg.sv -----
// types and constants for the smoothstep tween table
// used by smt_ctrl, smt_dp and smoothstep_motion_tween_table; no dependencies
package smt_pkg;

    localparam logic [16:0] ONE_Q16      = 17'h10000;
    localparam logic [17:0] THREE_Q16    = 18'h30000;
    localparam logic [15:0] DUR_RESET    = 16'd250;
    localparam logic [4:0]  DIV_STEPS    = 5'd16;
    localparam logic [9:0]  DONE_NUM     = 10'd1000;
    localparam logic [9:0]  DONE_DEN     = 10'd999;

    typedef enum logic [1:0] {
        MODE_ENQ    = 2'd0,
        MODE_CANCEL = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ,
        S_C_RD,
        S_C_CHK,
        S_T_RD,
        S_T_ELAP,
        S_T_CMP,
        S_T_DIV,
        S_T_M1,
        S_T_M2,
        S_T_MX,
        S_T_MY,
        S_T_EMIT
    } state_t;

    typedef struct packed {
        logic [15:0] obj;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] gx;
        logic [15:0] gy;
        logic [31:0] start_ms;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic enq;
        logic c_step;
        logic commit;
        logic elap;
        logic cmp;
        logic div_step;
        logic m1;
        logic m2;
        logic mx;
        logic my;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic at_end;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/core/smt_ctrl.sv -----
// controller state machine of the tween table
// depends on smt_pkg; drives commands into smt_dp
module smt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       mode,
    output logic             in_stall,
    input  smt_pkg::status_t sts,
    output smt_pkg::cmd_t    cmd
);
    import smt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode_t'(mode))
                        MODE_ENQ:    state_next = S_ENQ;
                        MODE_CANCEL: state_next = S_C_RD;
                        MODE_TICK:   state_next = S_T_RD;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_ENQ:    state_next = S_IDLE;
            S_C_RD:   state_next = sts.at_end ? S_IDLE : S_C_CHK;
            S_C_CHK:  state_next = S_C_RD;
            S_T_RD:   state_next = sts.at_end ? S_IDLE : S_T_ELAP;
            S_T_ELAP: state_next = S_T_CMP;
            S_T_CMP:  state_next = S_T_DIV;
            S_T_DIV:  state_next = sts.div_done ? S_T_M1 : S_T_DIV;
            S_T_M1:   state_next = S_T_M2;
            S_T_M2:   state_next = S_T_MX;
            S_T_MX:   state_next = S_T_MY;
            S_T_MY:   state_next = S_T_EMIT;
            S_T_EMIT: state_next = sts.out_free ? S_T_RD : S_T_EMIT;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            S_ENQ:    cmd.enq      = 1'b1;
            S_C_RD:   cmd.commit   = sts.at_end;
            S_C_CHK:  cmd.c_step   = 1'b1;
            S_T_RD:   cmd.commit   = sts.at_end;
            S_T_ELAP: cmd.elap     = 1'b1;
            S_T_CMP:  cmd.cmp      = 1'b1;
            S_T_DIV:  cmd.div_step = ~sts.div_done;
            S_T_M1:   cmd.m1       = 1'b1;
            S_T_M2:   cmd.m2       = 1'b1;
            S_T_MX:   cmd.mx       = 1'b1;
            S_T_MY:   cmd.my       = 1'b1;
            S_T_EMIT: cmd.emit     = sts.out_free;
            default:  cmd          = '0;
        endcase
    end

endmodule

// ----- rtl/core/smt_dp.sv -----
// datapath of the tween table: task memory, walk counters, divider,
// smoothstep multipliers and output register; depends on smt_pkg
module smt_dp #(
    parameter int MAX_TASKS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  smt_pkg::cmd_t      cmd,
    output smt_pkg::status_t   sts,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic [15:0]        object_id,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic signed [15:0] goal_x,
    input  logic signed [15:0] goal_y,
    input  logic [31:0]        now_ms,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        out_object_id,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic               finished,
    output logic               last
);
    import smt_pkg::*;

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_TASKS);

    entry_t mem [MAX_TASKS];
    entry_t entry_reg;
    entry_t in_reg;
    logic   [31:0] now_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] keep_reg;
    logic [15:0]   dur_reg;

    logic [31:0] elapsed_reg;
    logic        done_reg;
    logic [15:0] rem_reg;
    logic [15:0] quo_reg;
    logic [4:0]  div_cnt_reg;
    logic        clamp_reg;
    logic [16:0] t2_reg;
    logic [16:0] m_reg;
    logic signed [15:0] px_reg;
    logic signed [15:0] py_reg;

    logic        out_valid_reg;
    logic [15:0] out_obj_reg;
    logic [15:0] out_x_reg;
    logic [15:0] out_y_reg;
    logic        out_fin_reg;
    logic        out_last_reg;

    logic        we;
    logic [IW-1:0] waddr;
    entry_t      wdata;
    logic [16:0] rem2;
    logic [16:0] t_val;
    logic [33:0] tt;
    logic [17:0] fac;
    logic [34:0] tf;
    logic [41:0] lhs;
    logic [25:0] rhs;
    logic signed [15:0] b_start;
    logic signed [15:0] b_goal;
    logic signed [16:0] b_diff;
    logic signed [35:0] b_prod;
    logic signed [35:0] b_num;
    logic signed [19:0] b_pos;

    assign sts.at_end   = (i_reg == count_reg);
    assign sts.div_done = (div_cnt_reg == 5'd0);
    assign sts.out_free = ~out_valid_reg | ~out_stall;

    // memory writes: enqueue at the tail, compaction at the keep pointer
    always_comb
    begin
        we    = 1'b0;
        waddr = count_reg[IW-1:0];
        wdata = in_reg;
        if (cmd.enq && count_reg < MAX_COUNT)
            we = 1'b1;
        if (cmd.c_step && entry_reg.obj != in_reg.obj)
        begin
            we    = 1'b1;
            waddr = keep_reg[IW-1:0];
            wdata = entry_reg;
        end
        if (cmd.emit && !done_reg)
        begin
            we    = 1'b1;
            waddr = keep_reg[IW-1:0];
            wdata = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        entry_reg <= mem[i_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            i_reg     <= '0;
            keep_reg  <= '0;
            dur_reg   <= DUR_RESET;
        end
        else
        begin
            if (cfg_we)
                dur_reg <= cfg_wdata;
            if (cmd.capture)
            begin
                i_reg    <= '0;
                keep_reg <= '0;
            end
            if (cmd.enq && count_reg < MAX_COUNT)
                count_reg <= count_reg + 1'b1;
            if (cmd.c_step)
            begin
                i_reg <= i_reg + 1'b1;
                if (entry_reg.obj != in_reg.obj)
                    keep_reg <= keep_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                i_reg <= i_reg + 1'b1;
                if (!done_reg)
                    keep_reg <= keep_reg + 1'b1;
            end
            if (cmd.commit)
                count_reg <= keep_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg.obj      <= object_id;
            in_reg.sx       <= start_x;
            in_reg.sy       <= start_y;
            in_reg.gx       <= goal_x;
            in_reg.gy       <= goal_y;
            in_reg.start_ms <= now_ms;
            now_reg         <= now_ms;
        end
    end

    // progress division, one quotient bit a cycle; elapsed >= duration clamps to one
    assign rem2  = {rem_reg, 1'b0};
    assign lhs   = 42'(elapsed_reg) * 42'(DONE_NUM);
    assign rhs   = 26'(dur_reg) * 26'(DONE_DEN);
    assign t_val = clamp_reg ? ONE_Q16 : {1'b0, quo_reg};
    assign tt    = 34'(t_val) * 34'(t_val);
    assign fac   = THREE_Q16 - {t_val, 1'b0};
    assign tf    = 35'(t2_reg) * 35'(fac);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.cmp)
            div_cnt_reg <= (elapsed_reg >= 32'(dur_reg)) ? 5'd0 : DIV_STEPS;
        else if (cmd.div_step)
            div_cnt_reg <= div_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.elap)
            elapsed_reg <= now_reg - entry_reg.start_ms;
        if (cmd.cmp)
        begin
            done_reg  <= (lhs >= 42'(rhs));
            clamp_reg <= (elapsed_reg >= 32'(dur_reg));
            rem_reg   <= elapsed_reg[15:0];
            quo_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem2 >= 17'(dur_reg))
            begin
                rem_reg <= 16'(rem2 - 17'(dur_reg));
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem2[15:0];
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
        if (cmd.m1)
            t2_reg <= tt[32:16];
        if (cmd.m2)
            m_reg <= tf[32:16];
        if (cmd.mx)
            px_reg <= b_pos[15:0];
        if (cmd.my)
            py_reg <= b_pos[15:0];
    end

    // blend one axis: start - m*(start-goal), rounded toward zero
    always_comb
    begin
        b_start = cmd.my ? $signed(entry_reg.sy) : $signed(entry_reg.sx);
        b_goal  = cmd.my ? $signed(entry_reg.gy) : $signed(entry_reg.gx);
        b_diff  = 17'(b_start) - 17'(b_goal);
        b_prod  = 36'($signed({1'b0, m_reg}) * b_diff);
        b_num   = (36'(b_start) <<< 16) - b_prod;
        b_pos   = 20'(b_num >>> 16);
        if (b_num[35] && b_num[15:0] != 16'd0)
            b_pos = b_pos + 20'sd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_obj_reg  <= entry_reg.obj;
            out_x_reg    <= px_reg;
            out_y_reg    <= py_reg;
            out_fin_reg  <= done_reg;
            out_last_reg <= (i_reg + 1'b1 == count_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_object_id = out_obj_reg;
    assign pos_x         = out_x_reg;
    assign pos_y         = out_y_reg;
    assign finished      = out_fin_reg;
    assign last          = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT) else $error("task count above capacity");
    a_keep_behind: assert property (@(posedge clk) disable iff (!rst_n)
        keep_reg <= i_reg) else $error("keep pointer passed walk pointer");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free) else $error("result overwrote a waiting item");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.c_step || cmd.emit) |-> i_reg < count_reg)
        else $error("walk beyond table end");

endmodule

// ----- rtl/core/smoothstep_motion_tween_table.sv -----
// top level of the smoothstep tween table
// depends on smt_pkg, smt_ctrl and smt_dp
//
// usage:
//   input channel (in_valid/in_stall) carries one command item: mode 0 appends a
//   move task (dropped when the table is full), mode 1 removes all tasks of
//   object_id, mode 2 is a tick at time now_ms, mode 3 is ignored.
//   a tick gives one output item per stored task, in table order, on
//   out_valid/out_stall; finished marks a task that was removed, last marks
//   the final item of the tick. an empty table gives no items.
//   cfg_we/cfg_wdata write duration_ms at any edge; write only while idle.
// sequence per item:
//   enqueue writes the tail entry; cancel reads and checks each task in turn; a
//   tick takes each task through read, elapsed, compare, the progress divider
//   (16 quotient bits, one a cycle, then a finish step), two multiply steps,
//   two blend steps and the emit step. a task whose elapsed time has reached
//   the duration skips the quotient bits of the divider.
//   the block takes one item at a time; in_stall is high while it works.
// reset and stall:
//   reset empties the table and sets duration_ms to 250. a stalled result holds
//   in the output register, and the walk waits at its next emit until taken.
module smoothstep_motion_tween_table #(
    parameter int MAX_TASKS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [15:0]        object_id,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic signed [15:0] goal_x,
    input  logic signed [15:0] goal_y,
    input  logic [31:0]        now_ms,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        out_object_id,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic               finished,
    output logic               last
);
    import smt_pkg::*;

    cmd_t    cmd;
    status_t sts;

    smt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    smt_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .object_id     (object_id),
        .start_x       (start_x),
        .start_y       (start_y),
        .goal_x        (goal_x),
        .goal_y        (goal_y),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_object_id (out_object_id),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .finished      (finished),
        .last          (last)
    );

endmodule
